// ===== rtl/tgeqa_pkg.sv =====
`timescale 1ns / 1ps
package tgeqa_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_QUEUES  = 6;
    localparam int OFF_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int Q_W         = 3;
    localparam int ADDR_W      = Q_W + OFF_W;
    localparam int MEM_DEPTH   = NUM_QUEUES << OFF_W;
    localparam int TS_W        = 64;
    localparam int TAG_W       = 16;
    localparam int ENTRY_W     = TS_W + 1 + TAG_W;
    localparam int DROP_W      = 7;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;

    localparam logic [2:0] KIND_MARKET   = 3'd0;
    localparam logic [2:0] KIND_EXEC     = 3'd1;
    localparam logic [2:0] KIND_SERVICE  = 3'd2;
    localparam logic [2:0] KIND_COMMAND  = 3'd3;
    localparam logic [2:0] KIND_REMINDER = 3'd4;

    localparam logic [Q_W-1:0] Q_MARKET   = 3'd0;
    localparam logic [Q_W-1:0] Q_EXEC     = 3'd1;
    localparam logic [Q_W-1:0] Q_SERVICE  = 3'd2;
    localparam logic [Q_W-1:0] Q_COMMAND  = 3'd3;
    localparam logic [Q_W-1:0] Q_LOCAL    = 3'd4;
    localparam logic [Q_W-1:0] Q_EXCHANGE = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [2:0]       event_kind;
        logic             clock_is_local;
        logic             is_tick;
        logic [TS_W-1:0]  time_value;
        logic [TAG_W-1:0] event_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              has_event;
        logic [TAG_W-1:0]  out_tag;
        logic [2:0]        out_queue;
        logic [TS_W-1:0]   out_timestamp;
        logic              out_is_tick;
        logic [DROP_W-1:0] dropped_stale;
    } t_out_item;

endpackage

// ===== rtl/timestamp_gated_event_queue_arbiter_unit.sv =====
// Six-queue event arbiter with a held market event and a monotonic local time. One
// transaction is taken at a time (o_stall is high while busy). Push and set-time present
// their result in the cycle after acceptance. A pop walks a single entry memory: it
// reads the market head (moving it into the held slot when none is held), then the local
// and exchange reminder heads, decides, then reads the chosen head, and presents its
// result; it skips the final read when it returns the held event or nothing. In simulator
// mode a market entry older than local time is dropped as stale and the next one is read.
// Once the result is taken the block returns to idle and can accept the next transaction.
`timescale 1ns / 1ps
module timestamp_gated_event_queue_arbiter_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  tgeqa_pkg::t_in_item   i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tgeqa_pkg::t_out_item  o_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MKT  = 8'b0000_0010,
        S_MDAT = 8'b0000_0100,
        S_LOC  = 8'b0000_1000,
        S_LDAT = 8'b0001_0000,
        S_DEC  = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic [tgeqa_pkg::ENTRY_W-1:0] r_mem [tgeqa_pkg::MEM_DEPTH];
    logic [tgeqa_pkg::ENTRY_W-1:0] r_rd;
    logic [tgeqa_pkg::ADDR_W-1:0]  w_raddr;
    logic [tgeqa_pkg::ADDR_W-1:0]  w_waddr;
    logic                          w_we;

    logic [tgeqa_pkg::OFF_W-1:0] r_head [tgeqa_pkg::NUM_QUEUES];
    logic [tgeqa_pkg::CNT_W-1:0] r_cnt  [tgeqa_pkg::NUM_QUEUES];

    logic                          r_mode;
    logic                          r_held_v;
    logic [tgeqa_pkg::TS_W-1:0]    r_held_ts;
    logic [tgeqa_pkg::TAG_W:0]     r_held_tt;
    logic [tgeqa_pkg::TS_W-1:0]    r_local;
    logic [tgeqa_pkg::TS_W-1:0]    r_lts;
    logic [tgeqa_pkg::DROP_W-1:0]  r_drop;
    logic [tgeqa_pkg::Q_W-1:0]     r_sel;
    tgeqa_pkg::t_out_item          r_out;

    logic [tgeqa_pkg::Q_W-1:0]     w_pq;
    logic [tgeqa_pkg::OFF_W+1:0]   w_sum;
    logic [tgeqa_pkg::OFF_W-1:0]   w_slot;
    logic [tgeqa_pkg::TS_W-1:0]    w_rd_ts;
    logic                          w_loc_ok;
    logic                          w_xch_ok;
    logic                          w_pick_q;
    logic                          w_pick_held;
    logic [tgeqa_pkg::Q_W-1:0]     w_sel;
    logic                          w_accept;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign o_item   = r_out;
    assign w_rd_ts  = r_rd[tgeqa_pkg::ENTRY_W-1 -: tgeqa_pkg::TS_W];

    always_comb begin
        unique case (i_item.event_kind)
            tgeqa_pkg::KIND_MARKET:   w_pq = tgeqa_pkg::Q_MARKET;
            tgeqa_pkg::KIND_EXEC:     w_pq = tgeqa_pkg::Q_EXEC;
            tgeqa_pkg::KIND_SERVICE:  w_pq = tgeqa_pkg::Q_SERVICE;
            tgeqa_pkg::KIND_REMINDER: w_pq = i_item.clock_is_local ? tgeqa_pkg::Q_LOCAL
                                                                   : tgeqa_pkg::Q_EXCHANGE;
            default:                  w_pq = tgeqa_pkg::Q_COMMAND;
        endcase
        w_sum = {2'b00, r_head[w_pq]} + (tgeqa_pkg::OFF_W+2)'(r_cnt[w_pq]);
        if (w_sum >= (tgeqa_pkg::OFF_W+2)'(tgeqa_pkg::QUEUE_DEPTH)) begin
            w_slot = tgeqa_pkg::OFF_W'(w_sum - (tgeqa_pkg::OFF_W+2)'(tgeqa_pkg::QUEUE_DEPTH));
        end else begin
            w_slot = tgeqa_pkg::OFF_W'(w_sum);
        end
        w_we    = w_accept && (i_item.cmd == tgeqa_pkg::CMD_PUSH)
                  && (r_cnt[w_pq] < tgeqa_pkg::CNT_W'(tgeqa_pkg::QUEUE_DEPTH));
        w_waddr = {w_pq, w_slot};
    end

    always_comb begin
        w_loc_ok = (r_cnt[tgeqa_pkg::Q_LOCAL] != '0)
                   && (r_mode ? (r_held_v && (r_lts <= r_held_ts)) : (r_lts <= r_local));
        w_xch_ok = (r_cnt[tgeqa_pkg::Q_EXCHANGE] != '0) && r_held_v
                   && r_held_tt[tgeqa_pkg::TAG_W] && (w_rd_ts <= r_held_ts);
        w_pick_q    = 1'b1;
        w_pick_held = 1'b0;
        w_sel       = tgeqa_pkg::Q_MARKET;
        if (r_mode && r_cnt[tgeqa_pkg::Q_EXEC] != '0) begin
            w_sel = tgeqa_pkg::Q_EXEC;
        end else if (w_loc_ok) begin
            w_sel = tgeqa_pkg::Q_LOCAL;
        end else if (w_xch_ok) begin
            w_sel = tgeqa_pkg::Q_EXCHANGE;
        end else if (r_cnt[tgeqa_pkg::Q_EXEC] != '0) begin
            w_sel = tgeqa_pkg::Q_EXEC;
        end else if (r_cnt[tgeqa_pkg::Q_SERVICE] != '0) begin
            w_sel = tgeqa_pkg::Q_SERVICE;
        end else if (r_cnt[tgeqa_pkg::Q_COMMAND] != '0) begin
            w_sel = tgeqa_pkg::Q_COMMAND;
        end else begin
            w_pick_q    = 1'b0;
            w_pick_held = r_held_v;
        end
    end

    always_comb begin
        unique case (r_state)
            S_MKT:   w_raddr = {tgeqa_pkg::Q_MARKET, r_head[tgeqa_pkg::Q_MARKET]};
            S_LOC:   w_raddr = {tgeqa_pkg::Q_LOCAL, r_head[tgeqa_pkg::Q_LOCAL]};
            S_LDAT:  w_raddr = {tgeqa_pkg::Q_EXCHANGE, r_head[tgeqa_pkg::Q_EXCHANGE]};
            S_DEC:   w_raddr = {w_sel, r_head[w_sel]};
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= {i_item.time_value, i_item.is_tick, i_item.event_tag};
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_held_v  <= 1'b0;
            r_held_ts <= '0;
            r_held_tt <= '0;
            r_local   <= '0;
            r_drop    <= '0;
            for (int i = 0; i < tgeqa_pkg::NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_drop <= '0;
                        case (i_item.cmd)
                            tgeqa_pkg::CMD_PUSH: begin
                                r_state <= S_OUT;
                                if (w_we) begin
                                    r_cnt[w_pq] <= r_cnt[w_pq] + 1'b1;
                                    r_out <= '0;
                                end else begin
                                    r_out <= '{status: tgeqa_pkg::ST_FULL, default: '0};
                                end
                            end
                            tgeqa_pkg::CMD_POP: begin
                                r_out   <= '0;
                                r_state <= S_MKT;
                            end
                            tgeqa_pkg::CMD_SET: begin
                                r_state <= S_OUT;
                                if (i_item.time_value < r_local) begin
                                    r_out <= '{status: tgeqa_pkg::ST_REJECTED, default: '0};
                                end else begin
                                    r_out   <= '0;
                                    r_local <= i_item.time_value;
                                end
                            end
                            default: begin
                                r_out   <= '0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_MKT: begin
                    r_state <= (!r_held_v && r_cnt[tgeqa_pkg::Q_MARKET] != '0) ? S_MDAT : S_LOC;
                end
                S_MDAT: begin
                    if (r_head[tgeqa_pkg::Q_MARKET] == tgeqa_pkg::OFF_W'(tgeqa_pkg::QUEUE_DEPTH-1))
                    begin
                        r_head[tgeqa_pkg::Q_MARKET] <= '0;
                    end else begin
                        r_head[tgeqa_pkg::Q_MARKET] <= r_head[tgeqa_pkg::Q_MARKET] + 1'b1;
                    end
                    r_cnt[tgeqa_pkg::Q_MARKET] <= r_cnt[tgeqa_pkg::Q_MARKET] - 1'b1;
                    r_held_ts <= w_rd_ts;
                    r_held_tt <= r_rd[tgeqa_pkg::TAG_W:0];
                    if (r_mode && (w_rd_ts < r_local)) begin
                        if (r_drop != '1) begin
                            r_drop <= r_drop + 1'b1;
                        end
                        r_state <= S_MKT;
                    end else begin
                        r_held_v <= 1'b1;
                        r_state  <= S_LOC;
                    end
                end
                S_LOC:  r_state <= S_LDAT;
                S_LDAT: begin
                    r_lts   <= w_rd_ts;
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_out.dropped_stale <= r_drop;
                    if (w_pick_q) begin
                        r_sel <= w_sel;
                        if (r_head[w_sel] == tgeqa_pkg::OFF_W'(tgeqa_pkg::QUEUE_DEPTH-1)) begin
                            r_head[w_sel] <= '0;
                        end else begin
                            r_head[w_sel] <= r_head[w_sel] + 1'b1;
                        end
                        r_cnt[w_sel] <= r_cnt[w_sel] - 1'b1;
                        r_state <= S_EMIT;
                    end else if (w_pick_held) begin
                        r_held_v            <= 1'b0;
                        r_out.has_event     <= 1'b1;
                        r_out.out_tag       <= r_held_tt[tgeqa_pkg::TAG_W-1:0];
                        r_out.out_is_tick   <= r_held_tt[tgeqa_pkg::TAG_W];
                        r_out.out_timestamp <= r_held_ts;
                        r_out.out_queue     <= tgeqa_pkg::Q_MARKET;
                        r_state <= S_OUT;
                    end else begin
                        r_out.status <= tgeqa_pkg::ST_EMPTY;
                        r_state <= S_OUT;
                    end
                end
                S_EMIT: begin
                    r_out.has_event     <= 1'b1;
                    r_out.out_tag       <= r_rd[tgeqa_pkg::TAG_W-1:0];
                    r_out.out_is_tick   <= r_rd[tgeqa_pkg::TAG_W];
                    r_out.out_timestamp <= w_rd_ts;
                    r_out.out_queue     <= r_sel;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[tgeqa_pkg::Q_MARKET] <= tgeqa_pkg::CNT_W'(tgeqa_pkg::QUEUE_DEPTH))
        else $error("market count beyond depth");

    a_event_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.has_event |-> o_item.status == tgeqa_pkg::ST_OK)
        else $error("event returned with bad status");

    a_drop_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.dropped_stale != '0 |-> r_mode)
        else $error("stale drop outside simulator mode");

    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_local >= $past(r_local))
        else $error("local time moved backward");

endmodule

// ===== test/timestamp_gated_event_queue_arbiter_unit_tb.sv =====
`timescale 1ns / 1ps
module timestamp_gated_event_queue_arbiter_unit_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    tgeqa_pkg::t_in_item  in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    tgeqa_pkg::t_out_item out_item;
    logic                 cfg_we = 1'b0;
    logic                 cfg_data = 1'b0;

    timestamp_gated_event_queue_arbiter_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    // predictor state
    logic [tgeqa_pkg::TS_W-1:0] pq_ts [tgeqa_pkg::NUM_QUEUES][$];
    logic [tgeqa_pkg::TAG_W:0]  pq_tt [tgeqa_pkg::NUM_QUEUES][$];
    logic                       p_held_valid;
    logic [tgeqa_pkg::TS_W-1:0] p_held_ts;
    logic [tgeqa_pkg::TAG_W:0]  p_held_tt;
    logic [tgeqa_pkg::TS_W-1:0] p_local_time;
    logic                       p_mode;

    tgeqa_pkg::t_in_item  pending_items[$];
    tgeqa_pkg::t_out_item expected_results[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        stim_done = 0;

    function automatic void emit_event(ref tgeqa_pkg::t_out_item r, input logic [2:0] q,
                                       input logic [tgeqa_pkg::TS_W-1:0] ts,
                                       input logic [tgeqa_pkg::TAG_W:0] tt);
        r.status = tgeqa_pkg::ST_OK;
        r.has_event = 1'b1;
        r.out_tag = tt[tgeqa_pkg::TAG_W-1:0];
        r.out_queue = q;
        r.out_timestamp = ts;
        r.out_is_tick = tt[tgeqa_pkg::TAG_W];
    endfunction

    function automatic bit take_from(ref tgeqa_pkg::t_out_item r, input int q);
        if (pq_ts[q].size() == 0) return 0;
        emit_event(r, q[2:0], pq_ts[q].pop_front(), pq_tt[q].pop_front());
        return 1;
    endfunction

    function automatic bit take_if_due(ref tgeqa_pkg::t_out_item r, input int q,
                                       input logic [tgeqa_pkg::TS_W-1:0] lim);
        if (pq_ts[q].size() == 0 || pq_ts[q][0] > lim) return 0;
        return take_from(r, q);
    endfunction

    function automatic bit take_exchange(ref tgeqa_pkg::t_out_item r);
        if (!p_held_valid || !p_held_tt[tgeqa_pkg::TAG_W]) return 0;
        return take_if_due(r, tgeqa_pkg::Q_EXCHANGE, p_held_ts);
    endfunction

    function automatic tgeqa_pkg::t_out_item arbitrate(tgeqa_pkg::t_in_item it);
        tgeqa_pkg::t_out_item r;
        int q;
        int dropped;
        bit got;
        r = '0;
        dropped = 0;
        got = 0;
        case (it.cmd)
            tgeqa_pkg::CMD_PUSH: begin
                if (it.event_kind == tgeqa_pkg::KIND_REMINDER)
                    q = it.clock_is_local ? tgeqa_pkg::Q_LOCAL : tgeqa_pkg::Q_EXCHANGE;
                else if (it.event_kind <= tgeqa_pkg::KIND_COMMAND) q = it.event_kind;
                else q = tgeqa_pkg::Q_COMMAND;
                if (pq_ts[q].size() >= tgeqa_pkg::QUEUE_DEPTH) begin
                    r.status = tgeqa_pkg::ST_FULL;
                end else begin
                    pq_ts[q].push_back(it.time_value);
                    pq_tt[q].push_back({it.is_tick, it.event_tag});
                end
            end
            tgeqa_pkg::CMD_POP: begin
                if (p_mode) begin
                    while (!p_held_valid && pq_ts[tgeqa_pkg::Q_MARKET].size() != 0) begin
                        p_held_ts = pq_ts[tgeqa_pkg::Q_MARKET].pop_front();
                        p_held_tt = pq_tt[tgeqa_pkg::Q_MARKET].pop_front();
                        if (p_held_ts < p_local_time) begin
                            if (dropped < 127) dropped++;
                        end else begin
                            p_held_valid = 1'b1;
                        end
                    end
                    got = take_from(r, tgeqa_pkg::Q_EXEC);
                    if (!got && p_held_valid)
                        got = take_if_due(r, tgeqa_pkg::Q_LOCAL, p_held_ts);
                    if (!got) got = take_exchange(r);
                end else begin
                    if (!p_held_valid && pq_ts[tgeqa_pkg::Q_MARKET].size() != 0) begin
                        p_held_ts = pq_ts[tgeqa_pkg::Q_MARKET].pop_front();
                        p_held_tt = pq_tt[tgeqa_pkg::Q_MARKET].pop_front();
                        p_held_valid = 1'b1;
                    end
                    got = take_if_due(r, tgeqa_pkg::Q_LOCAL, p_local_time);
                    if (!got) got = take_exchange(r);
                    if (!got) got = take_from(r, tgeqa_pkg::Q_EXEC);
                end
                if (!got) got = take_from(r, tgeqa_pkg::Q_SERVICE);
                if (!got) got = take_from(r, tgeqa_pkg::Q_COMMAND);
                if (!got && p_held_valid) begin
                    p_held_valid = 1'b0;
                    emit_event(r, tgeqa_pkg::Q_MARKET, p_held_ts, p_held_tt);
                    got = 1;
                end
                if (!got) r.status = tgeqa_pkg::ST_EMPTY;
                r.dropped_stale = dropped[tgeqa_pkg::DROP_W-1:0];
            end
            tgeqa_pkg::CMD_SET: begin
                if (it.time_value < p_local_time) r.status = tgeqa_pkg::ST_REJECTED;
                else p_local_time = it.time_value;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // driver
    int drv_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(arbitrate(in_item));
                drv_gap = gap_len();
                if (drv_gap == 0 && pending_items.size() != 0) begin
                    in_item <= pending_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (!in_valid) begin
                if (drv_gap > 0) drv_gap--;
                else if (pending_items.size() != 0) begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor
    int rcv_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", 64'(out_item), 64'd0);
                end else begin
                    tgeqa_pkg::t_out_item e;
                    e = expected_results.pop_front();
                    if (out_item.status !== e.status)
                        report_mismatch("status", 64'(out_item.status), 64'(e.status));
                    if (out_item.has_event !== e.has_event)
                        report_mismatch("has_event", 64'(out_item.has_event),
                                        64'(e.has_event));
                    if (out_item.out_tag !== e.out_tag)
                        report_mismatch("out_tag", 64'(out_item.out_tag), 64'(e.out_tag));
                    if (out_item.out_queue !== e.out_queue)
                        report_mismatch("out_queue", 64'(out_item.out_queue),
                                        64'(e.out_queue));
                    if (out_item.out_timestamp !== e.out_timestamp)
                        report_mismatch("out_timestamp", out_item.out_timestamp,
                                        e.out_timestamp);
                    if (out_item.out_is_tick !== e.out_is_tick)
                        report_mismatch("out_is_tick", 64'(out_item.out_is_tick),
                                        64'(e.out_is_tick));
                    if (out_item.dropped_stale !== e.dropped_stale)
                        report_mismatch("dropped_stale", 64'(out_item.dropped_stale),
                                        64'(e.dropped_stale));
                end
            end
            if (rcv_gap > 0) begin
                rcv_gap--;
                out_stall <= 1'b1;
            end else begin
                rcv_gap = gap_len();
                out_stall <= (rcv_gap != 0);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else if (in_valid || expected_results.size() != 0 || !stim_done)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic tgeqa_pkg::t_in_item mk(logic [1:0] c, logic [2:0] k, logic loc,
                                               logic tk, logic [63:0] tv, logic [15:0] tg);
        tgeqa_pkg::t_in_item it;
        it.cmd = c;
        it.event_kind = k;
        it.clock_is_local = loc;
        it.is_tick = tk;
        it.time_value = tv;
        it.event_tag = tg;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // sequences of mostly well-formed traffic around a moving local time
    logic [63:0] base_time = 64'd1000;
    task automatic add_random(int n);
        tgeqa_pkg::t_in_item it;
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            it = mk(tgeqa_pkg::CMD_PUSH, 3'($urandom_range(4)), 1'($urandom), 1'($urandom),
                    base_time + 64'($urandom_range(200)) - 64'd100, 16'($urandom));
            if (p < 45) it.cmd = tgeqa_pkg::CMD_PUSH;
            else if (p < 85) it.cmd = tgeqa_pkg::CMD_POP;
            else if (p < 95) begin
                it.cmd = tgeqa_pkg::CMD_SET;
                if ($urandom_range(3) != 0) base_time = base_time + 64'($urandom_range(60));
                it.time_value = base_time + 64'($urandom_range(20)) - 64'd10;
            end else begin
                it.cmd = 2'($urandom_range(3));
                it.event_kind = 3'($urandom_range(7));
                it.time_value = rand64();
            end
            pending_items.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_mode(logic m);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        p_mode = m;
    endtask

    initial begin
        p_held_valid = 0;
        p_held_ts = '0;
        p_held_tt = '0;
        p_local_time = '0;
        p_mode = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_mode(1'b0);

        // directed: realtime ordering, extremes, odd kinds, unused command
        pending_items.push_back(mk(tgeqa_pkg::CMD_POP, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_MARKET, 0, 1,
                                   64'd50, 16'hFFFF));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_REMINDER, 0, 1,
                                   64'd40, 16'h0001));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_REMINDER, 1, 0,
                                   64'd0, 16'h0002));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_EXEC, 0, 0,
                                   '1, 16'h0003));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_SERVICE, 1, 1,
                                   64'd7, 16'h0004));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, 3'd7, 1, 1, 64'd8, 16'h0005));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, 3'd5, 0, 0, 64'd9, 16'h0006));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_COMMAND, 0, 0,
                                   64'd9, 16'h0000));
        pending_items.push_back(mk(2'd3, 3'd6, 1, 1, '1, 16'hFFFF));
        repeat (9) pending_items.push_back(mk(tgeqa_pkg::CMD_POP, 0, 0, 0, 0, 0));
        pending_items.push_back(mk(tgeqa_pkg::CMD_SET, 0, 0, 0, 64'd100, 0));
        pending_items.push_back(mk(tgeqa_pkg::CMD_SET, 0, 0, 0, 64'd100, 0));
        pending_items.push_back(mk(tgeqa_pkg::CMD_SET, 0, 0, 0, 64'd99, 0));
        // full queue
        for (int i = 0; i < tgeqa_pkg::QUEUE_DEPTH + 2; i++)
            pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_SERVICE, 0, i[0],
                                       64'(i), 16'(i)));
        for (int i = 0; i < tgeqa_pkg::QUEUE_DEPTH + 1; i++)
            pending_items.push_back(mk(tgeqa_pkg::CMD_POP, 0, 0, 0, 0, 0));
        wait_idle();

        // simulator mode: stale drops
        write_mode(1'b1);
        for (int i = 0; i < 10; i++)
            pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_MARKET, 0, 1,
                                       64'd90 + 64'(i), 16'(i)));
        pending_items.push_back(mk(tgeqa_pkg::CMD_PUSH, tgeqa_pkg::KIND_REMINDER, 1, 0,
                                   64'd95, 16'h00AA));
        repeat (4) pending_items.push_back(mk(tgeqa_pkg::CMD_POP, 0, 0, 0, 0, 0));
        wait_idle();

        base_time = 64'd1000;
        pending_items.push_back(mk(tgeqa_pkg::CMD_SET, 0, 0, 0, base_time, 0));
        add_random(250);
        wait_idle();
        write_mode(1'b0);
        add_random(250);
        wait_idle();
        write_mode(1'b1);
        add_random(250);
        wait_idle();
        write_mode(1'b0);
        // extreme local time then random
        pending_items.push_back(mk(tgeqa_pkg::CMD_SET, 0, 0, 0, '1, 0));
        for (int i = 0; i < 60; i++)
            pending_items.push_back(mk(2'($urandom_range(1)), 3'($urandom_range(7)),
                                       1'($urandom), 1'($urandom), rand64(),
                                       16'($urandom)));
        add_random(100);
        wait_idle();
        stim_done = 1;

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
